@@ hdl/mblc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mblc_pkg
// Shared widths, types and the digit extract function of the bit lane
// compactor.
// ----------------------------------------------------------------------------
package mblc_pkg;

  localparam int WORD_W        = 64;
  localparam int DIGIT_W       = 8;
  localparam int DIGIT_COUNT   = WORD_W / DIGIT_W;
  localparam int STEP_W        = $clog2(DIGIT_COUNT);
  localparam int FILL_W        = $clog2(WORD_W);
  localparam int KCNT_W        = $clog2(DIGIT_W + 1);
  localparam int LANES_W       = 13;
  localparam int MAX_WORDS_DEF = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } mblc_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic full_clear;
    logic col_clear;
  } mblc_ctl_t;

  typedef struct packed {
    logic full;
    logic fill_zero;
  } mblc_sts_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
    logic              last;
  } mblc_entry_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] bits;
    logic [KCNT_W-1:0]  count;
  } mblc_digit_t;

  // pext over one digit
  function automatic mblc_digit_t extract_digit(input logic [DIGIT_W-1:0] data,
                                                input logic [DIGIT_W-1:0] mask);
    mblc_digit_t res;
    res.bits  = '0;
    res.count = '0;
    for (int j = 0; j < DIGIT_W; j++) begin
      if (mask[j]) begin
        res.bits[res.count[KCNT_W-2:0]] = data[j];
        res.count = res.count + KCNT_W'(1);
      end
    end
    return res;
  endfunction

endpackage

@@ hdl/mblc_extract.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mblc_extract
// Serial lane extraction: shifts the source word out one digit per cycle while
// step is set, packs the kept bits and appends them to the running output word.
// ----------------------------------------------------------------------------
module mblc_extract #(
  parameter int MAX_WORDS = mblc_pkg::MAX_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mblc_pkg::mblc_ctl_t           ctl,
  input  logic [mblc_pkg::WORD_W-1:0]   data_word,
  input  logic [mblc_pkg::WORD_W-1:0]   keep_word,
  input  logic [mblc_pkg::LANES_W-1:0]  live_lanes,
  output mblc_pkg::mblc_sts_t           sts,
  output logic [mblc_pkg::WORD_W-1:0]   full_word,
  output logic [mblc_pkg::WORD_W-1:0]   acc
);
  import mblc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WORDS + 1);
  localparam int BASE_W = IDX_W + FILL_W;
  localparam int CMP_W  = (BASE_W > LANES_W) ? BASE_W : LANES_W;

  logic [WORD_W-1:0]         data_sr;
  logic [WORD_W-1:0]         keep_sr;
  logic [LANES_W-1:0]        remaining;
  logic [IDX_W-1:0]          word_index;
  logic [FILL_W-1:0]         fill;
  logic                      full;

  logic                      index_ok;
  logic [CMP_W-1:0]          lane_base;
  logic [CMP_W-1:0]          lanes_ext;
  logic [CMP_W-1:0]          lanes_left;
  logic [DIGIT_W-1:0]        window;
  mblc_digit_t               digit;
  logic [WORD_W+DIGIT_W-1:0] shifted;
  logic [FILL_W:0]           total;

  assign index_ok = word_index < IDX_W'(MAX_WORDS);

  // live lanes from the start of this word on
  assign lane_base  = CMP_W'({word_index, {FILL_W{1'b0}}});
  assign lanes_ext  = CMP_W'(live_lanes);
  assign lanes_left = (lanes_ext > lane_base) ? lanes_ext - lane_base : '0;

  always_comb begin
    for (int j = 0; j < DIGIT_W; j++) begin
      window[j] = remaining > LANES_W'(j);
    end
  end

  assign digit   = extract_digit(data_sr[DIGIT_W-1:0], keep_sr[DIGIT_W-1:0] & window);
  assign shifted = {{WORD_W{1'b0}}, digit.bits} << fill;
  assign total   = {1'b0, fill} + (FILL_W+1)'(digit.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
      fill       <= '0;
      full       <= 1'b0;
      acc        <= '0;
      remaining  <= '0;
    end else begin
      if (ctl.load) begin
        data_sr   <= data_word;
        keep_sr   <= index_ok ? keep_word : '0;
        remaining <= lanes_left[LANES_W-1:0];
        if (index_ok) begin
          word_index <= word_index + IDX_W'(1);
        end
      end
      if (ctl.step) begin
        data_sr   <= data_sr >> DIGIT_W;
        keep_sr   <= keep_sr >> DIGIT_W;
        remaining <= (remaining >= LANES_W'(DIGIT_W)) ? remaining - LANES_W'(DIGIT_W) : '0;
        fill      <= total[FILL_W-1:0];
        if (total[FILL_W]) begin
          full_word <= acc | shifted[WORD_W-1:0];
          full      <= 1'b1;
          acc       <= {{(WORD_W-DIGIT_W){1'b0}}, shifted[WORD_W+DIGIT_W-1:WORD_W]};
        end else begin
          acc <= acc | shifted[WORD_W-1:0];
        end
      end
      if (ctl.full_clear) begin
        full <= 1'b0;
      end
      if (ctl.col_clear) begin
        acc        <= '0;
        fill       <= '0;
        word_index <= '0;
      end
    end
  end

  assign sts.full      = full;
  assign sts.fill_zero = (fill == '0);

endmodule

@@ hdl/mblc_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mblc_out_queue
// Two-entry result queue that takes up to two words per cycle and hands
// them out in order.
// ----------------------------------------------------------------------------
module mblc_out_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  mblc_pkg::mblc_entry_t        push_a,
  input  mblc_pkg::mblc_entry_t        push_b,
  output logic [1:0]                   space,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mblc_pkg::WORD_W-1:0]  packed_word,
  output logic                         column_end
);
  import mblc_pkg::*;

  mblc_entry_t slot0, slot1;
  mblc_entry_t slot0_next, slot1_next;
  logic [1:0]  count, count_next;
  logic [1:0]  mid;

  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    mid        = count;
    if (count != 2'd0 && out_ready) begin
      slot0_next = slot1;
      mid        = count - 2'd1;
    end
    count_next = mid;
    if (push_a.valid) begin
      if (count_next == 2'd0) begin
        slot0_next = push_a;
      end else begin
        slot1_next = push_a;
      end
      count_next = count_next + 2'd1;
    end
    if (push_b.valid) begin
      if (count_next == 2'd0) begin
        slot0_next = push_b;
      end else begin
        slot1_next = push_b;
      end
      count_next = count_next + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  assign space       = 2'd2 - count;
  assign out_valid   = count != 2'd0;
  assign packed_word = slot0.word;
  assign column_end  = slot0.last;

endmodule

@@ hdl/masked_bit_lane_compactor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_bit_lane_compactor
// Masked bit extraction and compaction of packed bit columns into 64-bit
// words, eight lanes per cycle while the extractor runs.
// ----------------------------------------------------------------------------
// a source word passes through load, the run steps and finish into the
// result queue; a new source word is taken only in idle, after the last
// has finished; the serial extractor takes one 8-lane digit a cycle
// finish waits while the two-entry result queue lacks room
// synchronous reset clears live_lanes, the column state and the queue
// ----------------------------------------------------------------------------
module masked_bit_lane_compactor #(
  parameter int MAX_WORDS = mblc_pkg::MAX_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mblc_pkg::LANES_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mblc_pkg::WORD_W-1:0]   data_word,
  input  logic [mblc_pkg::WORD_W-1:0]   keep_word,
  input  logic                          column_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mblc_pkg::WORD_W-1:0]   packed_word,
  output logic                          column_end
);
  import mblc_pkg::*;

  mblc_state_t       state, state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [LANES_W-1:0] live_lanes;
  logic              last_q;

  mblc_ctl_t         ctl;
  mblc_sts_t         sts;
  logic [WORD_W-1:0] full_word;
  logic [WORD_W-1:0] acc;
  mblc_entry_t       push_a, push_b;
  mblc_entry_t       cand_a, cand_b;
  logic [1:0]        space;
  logic [1:0]        need;
  logic              finish_go;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_lanes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      live_lanes <= cfg_data;
    end
  end

  // result words of the finishing source word
  always_comb begin
    cand_a = '0;
    cand_b = '0;
    if (sts.full) begin
      cand_a.valid = 1'b1;
      cand_a.word  = full_word;
      cand_a.last  = last_q && sts.fill_zero;
      cand_b.valid = last_q && !sts.fill_zero;
      cand_b.word  = acc;
      cand_b.last  = 1'b1;
    end else if (last_q) begin
      cand_a.valid = 1'b1;
      cand_a.word  = sts.fill_zero ? '0 : acc;
      cand_a.last  = 1'b1;
    end
  end

  assign need      = 2'(cand_a.valid) + 2'(cand_b.valid);
  assign finish_go = (state == ST_FINISH) && (need <= space);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_cnt == STEP_W'(DIGIT_COUNT - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    ctl.load       = in_ready && in_valid;
    ctl.step       = (state == ST_RUN);
    ctl.full_clear = finish_go;
    ctl.col_clear  = finish_go && last_q;
    push_a         = cand_a;
    push_b         = cand_b;
    push_a.valid   = cand_a.valid && finish_go;
    push_b.valid   = cand_b.valid && finish_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      last_q   <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        last_q   <= column_last;
        step_cnt <= '0;
      end else if (ctl.step) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end
    end
  end

  mblc_extract #(
    .MAX_WORDS (MAX_WORDS)
  ) u_extract (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .data_word  (data_word),
    .keep_word  (keep_word),
    .live_lanes (live_lanes),
    .sts        (sts),
    .full_word  (full_word),
    .acc        (acc)
  );

  mblc_out_queue u_out_queue (
    .clk         (clk),
    .rst         (rst),
    .push_a      (push_a),
    .push_b      (push_b),
    .space       (space),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_word (packed_word),
    .column_end  (column_end)
  );

endmodule

@@ sim/mblc_compaction_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mblc_compaction_checker
// Watches the lane count write, source word and packed word channels of the
// bit lane compactor. Keeps its own copy of the live lane count and of the
// column state, predicts the packed words of every accepted source word and
// compares each accepted packed word, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module mblc_compaction_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [mblc_pkg::LANES_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [mblc_pkg::WORD_W-1:0]  data_word,
  input  logic [mblc_pkg::WORD_W-1:0]  keep_word,
  input  logic                         column_last,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [mblc_pkg::WORD_W-1:0]  packed_word,
  input  logic                         column_end,
  output int                           errors,
  output int                           pending
);

  localparam int W     = mblc_pkg::WORD_W;
  localparam int WORDS = mblc_pkg::MAX_WORDS_DEF;

  typedef struct {
    logic [W-1:0] word;
    logic         last;
  } packed_exp_t;

  packed_exp_t                  packed_q[$];
  packed_exp_t                  got_exp;
  logic [mblc_pkg::LANES_W-1:0] live_lanes;
  logic [W-1:0]                 acc;
  int                           fill;
  int                           col_index;
  int                           fail_count = 0;
  int                           queued = 0;

  assign errors  = fail_count;
  assign pending = queued;

  // lanes of source word idx that lie below the live lane count
  function automatic logic [W-1:0] lane_window(input int idx,
                                               input logic [mblc_pkg::LANES_W-1:0] lanes);
    int base;
    int left;
    base = idx * W;
    if (idx >= WORDS || int'(lanes) <= base) return '0;
    left = int'(lanes) - base;
    if (left >= W) return '1;
    return (64'd1 << left) - 64'd1;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic push_packed(input logic [W-1:0] word, input logic last);
    packed_exp_t e;
    e.word = word;
    e.last = last;
    packed_q.push_back(e);
  endtask

  // extract the kept lanes of one source word and append them to the column
  task automatic compact_word(input logic [W-1:0] d, input logic [W-1:0] k_in,
                              input logic l);
    logic [W-1:0] k;
    logic [W-1:0] ext;
    int           n;
    int           total;
    logic         full;
    packed_exp_t  e;
    k   = k_in & lane_window(col_index, live_lanes);
    ext = '0;
    n   = 0;
    for (int b = 0; b < W; b++) begin
      if (k[b]) begin
        ext[n] = d[b];
        n++;
      end
    end
    total = fill + n;
    full  = 1'b0;
    if (n != 0) acc = acc | (ext << fill);
    if (total >= W) begin
      push_packed(acc, 1'b0);
      full = 1'b1;
      acc  = (fill != 0) ? (ext >> (W - fill)) : '0;
      fill = total - W;
    end else begin
      fill = total;
    end
    if (col_index < WORDS) col_index++;
    if (l) begin
      if (fill != 0) begin
        push_packed(acc, 1'b1);
      end else if (full) begin
        e = packed_q.pop_back();
        e.last = 1'b1;
        packed_q.push_back(e);
      end else begin
        push_packed('0, 1'b1);
      end
      acc       = '0;
      fill      = 0;
      col_index = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      packed_q.delete();
      live_lanes = '0;
      acc        = '0;
      fill       = 0;
      col_index  = 0;
    end else begin
      if (cfg_valid && cfg_ready) live_lanes = cfg_data;
      if (in_valid && in_ready) compact_word(data_word, keep_word, column_last);
      if (out_valid && out_ready) begin
        if (packed_q.size() == 0) begin
          report_mismatch("unexpected packed word", packed_word, '0);
        end else begin
          got_exp = packed_q.pop_front();
          if (packed_word !== got_exp.word)
            report_mismatch("packed_word", packed_word, got_exp.word);
          if (column_end !== got_exp.last)
            report_mismatch("column_end", W'(column_end), W'(got_exp.last));
        end
      end
    end
    queued = packed_q.size();
  end

endmodule

@@ sim/masked_bit_lane_compactor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_bit_lane_compactor_tb
// Drives columns of source words with keep masks into the bit lane compactor
// under a range of live lane counts and stall patterns: directed columns for
// the boundary, flush and empty cases, then random columns, a few of them
// longer than the column capacity. A checker beside the block predicts and
// compares every packed word; this module gives the verdict.
// ----------------------------------------------------------------------------
module masked_bit_lane_compactor_tb;

  localparam int W = mblc_pkg::WORD_W;

  logic                         clk;
  logic                         rst;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [mblc_pkg::LANES_W-1:0] cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic [W-1:0]                 data_word;
  logic [W-1:0]                 keep_word;
  logic                         column_last;
  logic                         out_valid;
  logic                         out_ready;
  logic [W-1:0]                 packed_word;
  logic                         column_end;

  int errors;
  int pending;
  int send_gap = 10;
  int recv_gap = 88;

  masked_bit_lane_compactor dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .keep_word   (keep_word),
    .column_last (column_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_word (packed_word),
    .column_end  (column_end)
  );

  mblc_compaction_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .keep_word   (keep_word),
    .column_last (column_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_word (packed_word),
    .column_end  (column_end),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_gap);
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [W-1:0] rand_keep();
    logic [W-1:0] a;
    logic [W-1:0] b;
    a = rand_word();
    b = rand_word();
    case ($urandom_range(7))
      0:       return '1;
      1:       return '0;
      2:       return a & b;
      3:       return a | b;
      default: return a;
    endcase
  endfunction

  function automatic logic [mblc_pkg::LANES_W-1:0] pick_lanes(input int p);
    case (p)
      0:       return 13'd0;
      1:       return 13'd4096;
      2:       return 13'd1;
      3:       return 13'd63;
      4:       return 13'd64;
      5:       return 13'd65;
      6:       return 13'd4095;
      default: return ($urandom_range(1) == 0) ? 13'($urandom_range(0, 600))
                                               : 13'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic push_word(input logic [W-1:0] d, input logic [W-1:0] k,
                           input logic l);
    @(negedge clk);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_word   <= d;
    keep_word   <= k;
    column_last <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  // let every predicted word drain, plus the block latency for wordless items
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_lanes(input logic [mblc_pkg::LANES_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [mblc_pkg::LANES_W-1:0] lanes_v;
    int                           sent;
    int                           len;
    logic                         first;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    data_word   = '0;
    keep_word   = '0;
    column_last = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no live lanes after reset
    push_word('1, '1, 1'b1);
    push_word(rand_word(), '1, 1'b0);
    push_word(rand_word(), '1, 1'b1);
    settle();

    write_lanes(13'd4096);
    push_word('1, '1, 1'b1);
    push_word('0, '1, 1'b0);
    push_word('1, '1, 1'b1);
    push_word(rand_word(), 64'h0000_0000_FFFF_FFFF, 1'b0);
    push_word(rand_word(), '1, 1'b1);
    push_word('1, '0, 1'b1);
    push_word('1, 64'h1, 1'b0);
    push_word('0, 64'h8000_0000_0000_0000, 1'b1);
    repeat (3) push_word(rand_word(), rand_word(), 1'b0);
    push_word(rand_word(), rand_word(), 1'b1);
    settle();

    // live lanes end inside the second word
    write_lanes(13'd100);
    push_word('1, '1, 1'b0);
    push_word('1, '1, 1'b0);
    push_word('1, '1, 1'b1);
    settle();

    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_gap = 10;
        recv_gap = 88;
      end else if (p < 8) begin
        send_gap = 88;
        recv_gap = 10;
      end else begin
        send_gap = 0;
        recv_gap = 0;
      end
      lanes_v = pick_lanes(p);
      write_lanes(lanes_v);
      sent  = 0;
      first = 1'b1;
      while (sent < 80) begin
        // the first column is past capacity when nearly all lanes are live
        if (first && lanes_v >= 13'd4032) len = 66;
        else if ($urandom_range(29) == 0) len = $urandom_range(8, 20);
        else len = $urandom_range(1, 6);
        first = 1'b0;
        for (int w = 0; w < len; w++) push_word(rand_word(), rand_keep(), w == len - 1);
        sent += len;
      end
      settle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
